>>> design/dlpm_pkg.sv
// ----------------------------------------------------------------------------
// dlpm_pkg
// shared types and constants of the date list parser and matcher
// ----------------------------------------------------------------------------
package dlpm_pkg;

    localparam int TableEntries = 64;
    localparam int AddrW        = (TableEntries > 1) ? $clog2(TableEntries) : 1;
    localparam int CountW       = 7;
    localparam int DateW        = 24;
    localparam int FieldW       = 8;
    localparam int CfgDataW     = 7;
    localparam int CfgIndexW    = 1;
    localparam int InDataW      = 40;
    localparam int OutDataW     = 16;
    localparam int QueueDepth   = 2;
    localparam int QPtrW        = $clog2(QueueDepth);
    localparam int QCntW        = $clog2(QueueDepth + 1);

    localparam logic [CfgDataW-1:0] RecordLimitReset = 7'd45;
    localparam logic [6:0]          ByteMask         = 7'h7F;
    localparam logic [6:0]          ChCr             = 7'h0D;
    localparam logic [6:0]          ChLParen         = 7'h28;
    localparam logic [6:0]          ChRParen         = 7'h29;
    localparam logic [6:0]          ChDot            = 7'h2E;
    localparam logic [6:0]          ChZero           = 7'h30;
    localparam logic [6:0]          ChNine           = 7'h39;

    localparam logic [CfgIndexW-1:0] CFG_MONTH_MODE   = 1'b0;
    localparam logic [CfgIndexW-1:0] CFG_RECORD_LIMIT = 1'b1;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_BYTE   = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_BYTE,
        KIND_LOOKUP,
        KIND_NOP
    } kind_t;

    typedef enum logic [2:0] {
        CC_DIGIT,
        CC_DOT,
        CC_LPAREN,
        CC_RPAREN,
        CC_CR,
        CC_OTHER
    } cclass_t;

    typedef struct packed {
        kind_t             kind;
        cclass_t           cclass;
        logic [3:0]        digit;
        logic [FieldW-1:0] qday;
        logic [FieldW-1:0] qmonth;
        logic [FieldW-1:0] qyear;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic [CountW-1:0] stored_count;
        logic              record_dropped;
        logic              record_stored;
        logic [CountW-1:0] match_position;
    } result_t;

endpackage

>>> design/date_list_parser_and_matcher.sv
// ----------------------------------------------------------------------------
// date_list_parser_and_matcher
// parses a meter's date list reply into a date table and answers date lookups
// ----------------------------------------------------------------------------
// Each input word carries a command: clear, reply byte or lookup. A two-word
// queue after the input decouples the input from the execution side, and
// every word yields exactly one result word. A lookup scans the date table
// through its single read port, one entry per cycle, and stops at the first
// match; on a miss it reads every stored entry, and an empty table is
// answered without a scan. The table has 64 entries and needs no clearing
// pass.
// ----------------------------------------------------------------------------
module date_list_parser_and_matcher (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [dlpm_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [dlpm_pkg::CfgDataW-1:0]  cfg_wdata,
    // input words
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cmd, reply_byte, query_day, query_month, query_year
    input  logic [dlpm_pkg::InDataW-1:0]   s_tdata,
    // result words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // match_position, record_stored, record_dropped, stored_count
    output logic [dlpm_pkg::OutDataW-1:0]  m_tdata
);
    import dlpm_pkg::*;

    queue_head_t head;
    logic        pop;

    dlpm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .head     (head),
        .pop      (pop)
    );

    dlpm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> design/dlpm_ram.sv
// ----------------------------------------------------------------------------
// dlpm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module dlpm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
    input  logic [Width-1:0]                          wdata,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
    output logic [Width-1:0]                          rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/dlpm_front.sv
// ----------------------------------------------------------------------------
// dlpm_front
// accepts input words, decodes command and character class, queues them
// ----------------------------------------------------------------------------
module dlpm_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dlpm_pkg::InDataW-1:0] s_tdata,
    output dlpm_pkg::queue_head_t        head,
    input  logic                         pop
);
    import dlpm_pkg::*;

    item_t            slots_reg [QueueDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] fill_reg, fill_next;
    item_t            item_in;
    logic [1:0]       cmd;
    logic [6:0]       ch;
    logic             push;

    assign cmd = s_tdata[1:0];
    assign ch  = s_tdata[8:2] & ByteMask;

    always_comb begin
        unique case (cmd)
            CMD_CLEAR:  item_in.kind = KIND_CLEAR;
            CMD_BYTE:   item_in.kind = KIND_BYTE;
            CMD_LOOKUP: item_in.kind = KIND_LOOKUP;
            default:    item_in.kind = KIND_NOP;
        endcase
        if (ch >= ChZero && ch <= ChNine) begin
            item_in.cclass = CC_DIGIT;
        end else if (ch == ChDot) begin
            item_in.cclass = CC_DOT;
        end else if (ch == ChLParen) begin
            item_in.cclass = CC_LPAREN;
        end else if (ch == ChRParen) begin
            item_in.cclass = CC_RPAREN;
        end else if (ch == ChCr) begin
            item_in.cclass = CC_CR;
        end else begin
            item_in.cclass = CC_OTHER;
        end
        item_in.digit  = ch[3:0];
        item_in.qday   = s_tdata[17:10];
        item_in.qmonth = s_tdata[25:18];
        item_in.qyear  = s_tdata[33:26];
    end

    assign s_tready = (fill_reg != QCntW'(QueueDepth));
    assign push     = s_tvalid && s_tready;

    assign head.valid = (fill_reg != '0);
    assign head.item  = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + QCntW'(push) - QCntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= item_in;
        end
    end

    // pop only from a non-empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (fill_reg != '0))
        else $error("queue popped while empty");

endmodule

>>> design/dlpm_back.sv
// ----------------------------------------------------------------------------
// dlpm_back
// parser, date table and sequential lookup, with registered result word
// ----------------------------------------------------------------------------
module dlpm_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [dlpm_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [dlpm_pkg::CfgDataW-1:0]  cfg_wdata,
    input  dlpm_pkg::queue_head_t          head,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dlpm_pkg::OutDataW-1:0]  m_tdata
);
    import dlpm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } state_t;

    typedef enum logic [3:0] {
        PH_SCAN = 4'b0001,
        PH_DAY  = 4'b0010,
        PH_MON  = 4'b0100,
        PH_YEAR = 4'b1000
    } phase_t;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic                month_mode_reg;
    logic [CfgDataW-1:0] record_limit_reg;
    logic [CountW-1:0]   entry_count_reg, entry_count_next;
    logic [FieldW-1:0]   acc_reg, acc_next;
    logic [FieldW-1:0]   pend_day_reg, pend_day_next;
    logic [FieldW-1:0]   pend_mon_reg, pend_mon_next;
    logic [FieldW-1:0]   pend_year_reg, pend_year_next;
    logic [FieldW-1:0]   q_day_reg, q_day_next;
    logic [FieldW-1:0]   q_mon_reg, q_mon_next;
    logic [FieldW-1:0]   q_year_reg, q_year_next;
    logic [AddrW-1:0]    rd_idx_reg, rd_idx_next;
    logic [AddrW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic                out_free;
    logic                can_store;
    logic                hit;
    logic                last;
    logic                ram_we;
    logic [DateW-1:0]    ram_rdata;

    assign out_free  = !out_valid_reg || m_tready;
    assign can_store = (32'(entry_count_reg) < 32'(record_limit_reg))
                    && (32'(entry_count_reg) < TableEntries);
    assign hit  = (ram_rdata[15:8] == q_mon_reg) && (ram_rdata[7:0] == q_year_reg)
               && (month_mode_reg || (ram_rdata[23:16] == q_day_reg));
    assign last = ((CountW'(cmp_idx_reg) + 1'b1) == entry_count_reg);

    dlpm_ram #(
        .Width (DateW),
        .Depth (TableEntries)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (entry_count_reg[AddrW-1:0]),
        .wdata ({pend_day_reg, pend_mon_reg, pend_year_reg}),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        entry_count_next = entry_count_reg;
        acc_next         = acc_reg;
        pend_day_next    = pend_day_reg;
        pend_mon_next    = pend_mon_reg;
        pend_year_next   = pend_year_reg;
        q_day_next       = q_day_reg;
        q_mon_next       = q_mon_reg;
        q_year_next      = q_year_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_idx_next     = cmp_idx_reg;
        cmp_vld_next     = cmp_vld_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_next         = out_reg;
        pop              = 1'b0;
        ram_we           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (head.valid && out_free) begin
                    pop                    = 1'b1;
                    out_next.match_position = '0;
                    out_next.record_stored  = 1'b0;
                    out_next.record_dropped = 1'b0;
                    unique case (head.item.kind)
                        KIND_CLEAR: begin
                            entry_count_next = '0;
                            phase_next       = PH_SCAN;
                            acc_next         = '0;
                            pend_day_next    = '0;
                            pend_mon_next    = '0;
                            pend_year_next   = '0;
                            out_valid_next   = 1'b1;
                        end
                        KIND_BYTE: begin
                            out_valid_next = 1'b1;
                            unique case (phase_reg)
                                PH_SCAN: begin
                                    if (head.item.cclass == CC_CR) begin
                                        if (can_store) begin
                                            ram_we                 = 1'b1;
                                            entry_count_next       = entry_count_reg + 1'b1;
                                            out_next.record_stored = 1'b1;
                                        end else begin
                                            out_next.record_dropped = 1'b1;
                                        end
                                        acc_next       = '0;
                                        pend_day_next  = '0;
                                        pend_mon_next  = '0;
                                        pend_year_next = '0;
                                    end else if (head.item.cclass == CC_LPAREN) begin
                                        acc_next   = '0;
                                        phase_next = month_mode_reg ? PH_MON : PH_DAY;
                                    end
                                end
                                PH_DAY: begin
                                    if (head.item.cclass == CC_DIGIT) begin
                                        acc_next = (acc_reg << 3) + (acc_reg << 1)
                                                 + FieldW'(head.item.digit);
                                    end else if (head.item.cclass == CC_DOT) begin
                                        pend_day_next = acc_reg;
                                        acc_next      = '0;
                                        phase_next    = PH_MON;
                                    end
                                end
                                PH_MON: begin
                                    if (head.item.cclass == CC_DIGIT) begin
                                        acc_next = (acc_reg << 3) + (acc_reg << 1)
                                                 + FieldW'(head.item.digit);
                                    end else if (head.item.cclass == CC_DOT) begin
                                        pend_mon_next = acc_reg;
                                        acc_next      = '0;
                                        phase_next    = PH_YEAR;
                                    end
                                end
                                PH_YEAR: begin
                                    if (head.item.cclass == CC_DIGIT) begin
                                        acc_next = (acc_reg << 3) + (acc_reg << 1)
                                                 + FieldW'(head.item.digit);
                                    end else if (head.item.cclass == CC_RPAREN) begin
                                        pend_year_next = acc_reg;
                                        acc_next       = '0;
                                        phase_next     = PH_SCAN;
                                    end
                                end
                                default: phase_next = PH_SCAN;
                            endcase
                        end
                        KIND_LOOKUP: begin
                            q_day_next  = head.item.qday;
                            q_mon_next  = head.item.qmonth;
                            q_year_next = head.item.qyear;
                            if (entry_count_reg == '0) begin
                                out_valid_next = 1'b1;
                            end else begin
                                rd_idx_next  = '0;
                                cmp_vld_next = 1'b0;
                                state_next   = ST_LOOK;
                            end
                        end
                        default: begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                    out_next.stored_count = entry_count_next;
                end
            end
            ST_LOOK: begin
                // one table read issued per cycle, compared in the cycle after
                rd_idx_next  = rd_idx_reg + 1'b1;
                cmp_idx_next = rd_idx_reg;
                cmp_vld_next = 1'b1;
                if (cmp_vld_reg && (hit || last)) begin
                    out_valid_next          = 1'b1;
                    out_next.match_position = hit ? CountW'(cmp_idx_reg) + 1'b1 : '0;
                    out_next.record_stored  = 1'b0;
                    out_next.record_dropped = 1'b0;
                    out_next.stored_count   = entry_count_reg;
                    cmp_vld_next            = 1'b0;
                    state_next              = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_SCAN;
            entry_count_reg  <= '0;
            acc_reg          <= '0;
            pend_day_reg     <= '0;
            pend_mon_reg     <= '0;
            pend_year_reg    <= '0;
            cmp_vld_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            month_mode_reg   <= 1'b0;
            record_limit_reg <= RecordLimitReset;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            entry_count_reg <= entry_count_next;
            acc_reg         <= acc_next;
            pend_day_reg    <= pend_day_next;
            pend_mon_reg    <= pend_mon_next;
            pend_year_reg   <= pend_year_next;
            cmp_vld_reg     <= cmp_vld_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_MONTH_MODE:   month_mode_reg   <= cfg_wdata[0];
                    CFG_RECORD_LIMIT: record_limit_reg <= cfg_wdata;
                    default:          month_mode_reg   <= month_mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_day_reg   <= q_day_next;
        q_mon_reg   <= q_mon_next;
        q_year_reg  <= q_year_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // the result register stays empty while a search runs
    a_look_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK) |-> !out_valid_reg)
        else $error("result pending during table search");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(entry_count_reg) <= TableEntries)
        else $error("entry count beyond table size");

    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE) && pop)
        else $error("table written outside a reply byte");

    a_store_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> (entry_count_reg == $past(entry_count_reg) + 1'b1))
        else $error("stored record did not advance the count");

endmodule

>>> tb/tb_date_list_parser_and_matcher.sv
// ----------------------------------------------------------------------------
// tb_date_list_parser_and_matcher
// self-checking bench for the date list parser and matcher
// ----------------------------------------------------------------------------
// A queue of command words is filled per phase and played into the input
// stream with random gaps. A predictor of the parser, the date table and the
// lookup runs on every accepted word. Each result word is compared field by
// field with the oldest prediction. Phases change the month mode and the
// record limit while the block is idle. Phases cover the table filling up,
// month-mode records and a long output stall.
// ----------------------------------------------------------------------------
module tb_date_list_parser_and_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    import dlpm_pkg::*;

    localparam int         CycleLimit = 1000000;
    localparam int         DrainWait  = 80;
    localparam logic [1:0] CmdUnused  = 2'd3;

    typedef enum logic [1:0] {
        PH_SCAN,
        PH_DAY,
        PH_MON,
        PH_YEAR
    } parse_ph_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OutDataW-1:0]  m_tdata;

    // predictor state
    logic [DateW-1:0]  date_mem [TableEntries];
    logic [CountW-1:0] date_cnt;
    parse_ph_t         ph;
    logic [7:0]        acc;
    logic [7:0]        p_day;
    logic [7:0]        p_mon;
    logic [7:0]        p_year;
    logic              cur_mode;
    logic [6:0]        cur_limit;

    logic [InDataW-1:0] pending_words [$];
    result_t            expected_results [$];

    int words_pushed;
    int words_taken;
    int mismatches;
    int cycle_cnt;
    int src_wait;
    int snk_wait;
    int src_gap_max;
    int snk_gap_max;
    int hold_left;
    bit word_taken;
    bit result_taken;

    date_list_parser_and_matcher u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void reset_parse();
        ph     = PH_SCAN;
        acc    = '0;
        p_day  = '0;
        p_mon  = '0;
        p_year = '0;
    endfunction

    function automatic result_t date_step(logic [InDataW-1:0] w);
        logic [6:0] ch;
        logic [7:0] qd;
        logic [7:0] qm;
        logic [7:0] qy;
        int         cap;
        int         i;
        result_t    r;
        ch  = w[8:2];
        qd  = w[17:10];
        qm  = w[25:18];
        qy  = w[33:26];
        r   = '0;
        cap = (cur_limit > TableEntries) ? TableEntries : cur_limit;
        case (w[1:0])
            CMD_CLEAR: begin
                date_cnt = '0;
                reset_parse();
            end
            CMD_BYTE: begin
                if (ph == PH_SCAN) begin
                    if (ch == ChCr) begin
                        if (date_cnt < cap) begin
                            date_mem[date_cnt] = {p_day, p_mon, p_year};
                            date_cnt = date_cnt + 1'b1;
                            r.record_stored = 1'b1;
                        end else begin
                            r.record_dropped = 1'b1;
                        end
                        reset_parse();
                    end else if (ch == ChLParen) begin
                        acc = '0;
                        ph  = cur_mode ? PH_MON : PH_DAY;
                    end
                end else if (ch >= ChZero && ch <= ChNine) begin
                    acc = 8'(acc * 10 + (ch - ChZero));
                end else if (ph == PH_DAY && ch == ChDot) begin
                    p_day = acc;
                    acc   = '0;
                    ph    = PH_MON;
                end else if (ph == PH_MON && ch == ChDot) begin
                    p_mon = acc;
                    acc   = '0;
                    ph    = PH_YEAR;
                end else if (ph == PH_YEAR && ch == ChRParen) begin
                    p_year = acc;
                    acc    = '0;
                    ph     = PH_SCAN;
                end
            end
            CMD_LOOKUP: begin
                for (i = 0; i < date_cnt; i++) begin
                    if (r.match_position == '0 && date_mem[i][15:8] == qm
                            && date_mem[i][7:0] == qy
                            && (cur_mode || date_mem[i][23:16] == qd)) begin
                        r.match_position = 7'(i + 1);
                    end
                end
            end
            default: begin
            end
        endcase
        r.stored_count = date_cnt;
        return r;
    endfunction

    task automatic check_field(string nm, int exp_v, int got_v);
        if (exp_v != got_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, nm, exp_v, got_v);
            mismatches++;
        end
    endtask

    // input acceptance, result checking and the run limit
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
            $display("%0t ns: run limit reached", $time);
            $display("tb_date_list_parser_and_matcher failed");
            $finish;
        end else if (aresetn) begin
            if (m_tvalid && m_tready) begin
                result_taken = 1'b1;
                got = result_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result word, expected none, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("match_position", want.match_position, got.match_position);
                    check_field("record_stored", want.record_stored, got.record_stored);
                    check_field("record_dropped", want.record_dropped, got.record_dropped);
                    check_field("stored_count", want.stored_count, got.stored_count);
                end
            end
            if (s_tvalid && s_tready) begin
                word_taken = 1'b1;
                words_taken++;
                expected_results.push_back(date_step(s_tdata));
            end
        end
    end

    // input driver
    always @(negedge aclk) begin
        if (!s_tvalid || word_taken) begin
            word_taken = 1'b0;
            if (src_wait > 0) begin
                src_wait--;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                s_tdata  <= pending_words.pop_front();
                s_tvalid <= 1'b1;
                src_wait = $urandom_range(0, src_gap_max);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output ready with per-word gaps
    always @(negedge aclk) begin
        if (result_taken) begin
            result_taken = 1'b0;
            snk_wait = $urandom_range(0, snk_gap_max);
        end
        if (snk_wait > 0) begin
            snk_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_left == 0);
        end
    end

    // long output stall
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
        end
    end

    task automatic push_word(logic [1:0] cmd, logic [7:0] rb, logic [7:0] d,
                             logic [7:0] m, logic [7:0] y);
        pending_words.push_back({6'b0, y, m, d, rb, cmd});
        words_pushed++;
    endtask

    task automatic push_byte(logic [7:0] b);
        push_word(CMD_BYTE, b, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic push_text(string s);
        int         i;
        logic [7:0] b;
        for (i = 0; i < s.len(); i++) begin
            b = s[i];
            if ($urandom_range(0, 5) == 0) begin
                b[7] = 1'b1;
            end
            push_byte(b);
        end
    endtask

    task automatic push_cr();
        push_byte({$urandom_range(0, 1) == 1, ChCr});
    endtask

    function automatic int pick_num();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return $urandom_range(1, 3);
        end else if (r < 8) begin
            return $urandom_range(0, 255);
        end
        return $urandom_range(0, 999);
    endfunction

    function automatic string num_text(int v);
        if ($urandom_range(0, 7) == 0) begin
            return $sformatf("0%0d", v);
        end
        return $sformatf("%0d", v);
    endfunction

    task automatic random_traffic(int n);
        int   stop;
        int   r;
        int   d;
        int   m;
        int   y;
        logic as_month;
        stop = words_pushed + n;
        while (words_pushed < stop) begin
            r = $urandom_range(0, 99);
            d = pick_num();
            m = pick_num();
            y = pick_num();
            if (r < 58) begin
                as_month = ($urandom_range(0, 9) == 0) ? !cur_mode : cur_mode;
                if (as_month) begin
                    push_text({"(", num_text(m), ".", num_text(y), ")"});
                end else begin
                    push_text({"(", num_text(d), ".", num_text(m), ".", num_text(y), ")"});
                end
                push_cr();
            end else if (r < 74) begin
                push_word(CMD_LOOKUP, 8'($urandom), 8'(d), 8'(m), 8'(y));
            end else if (r < 82) begin
                push_byte(8'($urandom));
            end else if (r < 94) begin
                case ($urandom_range(0, 2))
                    0: begin
                        // carriage return inside the group is ignored
                        push_text({"(", num_text(d)});
                        push_cr();
                        push_text({".", num_text(m), ".", num_text(y), ")"});
                    end
                    1: push_text({"(", num_text(d), ".", num_text(m), ")"});
                    default: begin
                        push_text({"(", num_text(d), ".", num_text(m), ".", num_text(y), ")"});
                        push_text({"(", num_text(y), ".", num_text(d), ".", num_text(m), ")"});
                    end
                endcase
                push_cr();
            end else if (r < 96) begin
                push_word(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (r < 98) begin
                push_word(CmdUnused, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                push_word(CMD_LOOKUP, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        while (words_taken != words_pushed || expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DrainWait) @(negedge aclk);
    endtask

    task automatic write_cfg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MONTH_MODE) begin
            cur_mode = val[0];
        end else begin
            cur_limit = val;
        end
    endtask

    task automatic start_phase(logic mode, int limit, int src_max, int snk_max);
        wait_drained();
        write_cfg(CFG_MONTH_MODE, CfgDataW'(mode));
        write_cfg(CFG_RECORD_LIMIT, CfgDataW'(limit));
        src_gap_max = src_max;
        snk_gap_max = snk_max;
    endtask

    initial begin
        int i;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        words_pushed = 0;
        words_taken  = 0;
        mismatches   = 0;
        cycle_cnt    = 0;
        src_wait     = 0;
        snk_wait     = 0;
        src_gap_max  = 18;
        snk_gap_max  = 18;
        hold_left    = 0;
        word_taken   = 1'b0;
        result_taken = 1'b0;
        date_cnt     = '0;
        cur_mode     = 1'b0;
        cur_limit    = RecordLimitReset;
        reset_parse();
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // reset defaults: day mode, limit 45
        push_word(CmdUnused, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte({1'b1, ChCr});
        push_text("(300.12.99");
        push_byte({1'b1, ChRParen});
        push_byte({1'b0, ChCr});
        push_word(CMD_LOOKUP, 8'h00, 8'd44, 8'd12, 8'd99);
        push_word(CMD_LOOKUP, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        push_word(CMD_LOOKUP, 8'hFF, 8'h00, 8'h00, 8'h00);
        push_word(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_text("(1.)(4.5.6)");
        push_cr();
        push_word(CMD_LOOKUP, 8'h00, 8'd4, 8'd5, 8'd6);
        random_traffic(30);

        // smallest limit: second record dropped
        start_phase(1'b0, 1, 18, 18);
        push_word(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
        push_cr();
        push_text("(5.6.7)");
        push_cr();
        push_word(CMD_LOOKUP, 8'h00, 8'h00, 8'h00, 8'h00);
        push_word(CMD_LOOKUP, 8'h00, 8'd5, 8'd6, 8'd7);
        random_traffic(40);

        // month mode, full table, long output stall
        start_phase(1'b1, TableEntries, 0, 0);
        hold_left = 400;
        push_word(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
        push_text("(7.24)");
        push_cr();
        push_word(CMD_LOOKUP, 8'h00, 8'hFF, 8'd7, 8'd24);
        for (i = 0; i < TableEntries + 1; i++) begin
            push_cr();
        end
        push_word(CMD_LOOKUP, 8'h00, 8'd1, 8'd1, 8'd1);
        push_word(CMD_LOOKUP, 8'h00, 8'd9, 8'd0, 8'd0);
        random_traffic(40);

        start_phase(1'b1, 3, 18, 18);
        push_word(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
        random_traffic(40);

        start_phase(1'b0, 45, 0, 0);
        push_word(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
        random_traffic(60);

        start_phase(1'b0, 20, 18, 0);
        random_traffic(60);

        start_phase(1'b1, TableEntries, 0, 18);
        random_traffic(50);

        wait_drained();
        if (mismatches == 0) begin
            $display("tb_date_list_parser_and_matcher passed");
        end else begin
            $display("tb_date_list_parser_and_matcher failed");
        end
        $finish;
    end

endmodule

>>> date_list_parser_and_matcher.f
design/dlpm_pkg.sv
design/dlpm_ram.sv
design/dlpm_front.sv
design/dlpm_back.sv
design/date_list_parser_and_matcher.sv
tb/tb_date_list_parser_and_matcher.sv
